FILE: hw/rtl/pfsc_pkg.sv
package pfsc_pkg;

    // Default sizing of the page tables
    localparam int DEF_PROCESSES         = 16;
    localparam int DEF_PAGES_PER_PROCESS = 32;
    localparam int DEF_FRAMES            = 256;
    localparam int DEF_PAGE_BYTES        = 1024;

    // Fixed widths of the port fields
    localparam int SLOT_W      = 4;
    localparam int ADDR_W      = 15;
    localparam int FRAME_NUM_W = 8;
    localparam int CHANCE_W    = 9;

endpackage

FILE: hw/rtl/pfsc_cdiv.sv
// Divide an unsigned value by a constant: reciprocal multiply, then one
// compare and subtract to fix the quotient.
module pfsc_cdiv #(
    parameter int WIDTH   = pfsc_pkg::ADDR_W,
    parameter int DIVISOR = pfsc_pkg::DEF_PAGE_BYTES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int DW    = $clog2(DIVISOR + 1);
    localparam int SHIFT = WIDTH + $clog2(DIVISOR);
    localparam int MW    = SHIFT + 1;
    localparam int PW    = WIDTH + MW;
    localparam int BW    = WIDTH + DW;
    localparam logic [MW-1:0] RECIP = MW'((64'd1 << SHIFT) / DIVISOR);

    logic             s1_valid_reg;
    logic [WIDTH-1:0] s1_dividend_reg;
    logic [PW-1:0]    s1_product_reg;
    logic             done_reg;
    logic [WIDTH-1:0] quotient_reg;
    logic [WIDTH-1:0] remainder_reg;

    logic [WIDTH-1:0] q0;
    logic [BW-1:0]    back;
    logic [WIDTH-1:0] r0;
    logic             fix;

    // Stage one: multiply by the reciprocal
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_dividend_reg <= dividend;
            s1_product_reg  <= {{MW{1'b0}}, dividend} * {{WIDTH{1'b0}}, RECIP};
        end
    end

    // Stage two: estimate is exact or one short; correct it
    always_comb
    begin
        q0   = s1_product_reg[SHIFT +: WIDTH];
        back = BW'(q0) * BW'(DIVISOR);
        r0   = s1_dividend_reg - WIDTH'(back);
        fix  = (BW'(r0) >= BW'(DIVISOR));
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            quotient_reg  <= fix ? q0 + 1'b1 : q0;
            remainder_reg <= fix ? r0 - WIDTH'(DIVISOR) : r0;
        end
    end

    assign done      = done_reg;
    assign quotient  = quotient_reg;
    assign remainder = remainder_reg;

endmodule

FILE: hw/rtl/page_fault_second_chance_manager.sv
// Channel | Direction | Handshake            | Fields
// in      | input     | in_valid / in_stall   | process_slot, byte_address, is_write
// out     | output    | out_valid / out_stall | frame_number, page_fault, evicted,
//         |           |                       | second_chances
//
// An access is worked through to ST_DONE before the next is accepted, as in_stall
// is high outside ST_IDLE. Each access passes through the two chained constant
// dividers and the registered reads of the page table and frame table memories;
// a replacement adds a scan, which reads one frame a cycle.
// After reset the page table is swept clear, entry by entry, with in_stall high.
// A result waits in the output register while out_stall is high; the next word
// is accepted meanwhile.
module page_fault_second_chance_manager #(
    parameter int PROCESSES         = pfsc_pkg::DEF_PROCESSES,
    parameter int PAGES_PER_PROCESS = pfsc_pkg::DEF_PAGES_PER_PROCESS,
    parameter int FRAMES            = pfsc_pkg::DEF_FRAMES,
    parameter int PAGE_BYTES        = pfsc_pkg::DEF_PAGE_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [pfsc_pkg::SLOT_W-1:0]      process_slot,
    input  logic [pfsc_pkg::ADDR_W-1:0]      byte_address,
    input  logic                             is_write,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [pfsc_pkg::FRAME_NUM_W-1:0] frame_number,
    output logic                             page_fault,
    output logic                             evicted,
    output logic [pfsc_pkg::CHANCE_W-1:0]    second_chances
);

    localparam int SW       = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int PGW      = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
    localparam int FW       = $clog2(FRAMES);
    localparam int UW       = $clog2(FRAMES + 1);
    localparam int PT_DEPTH = PROCESSES * PAGES_PER_PROCESS;
    localparam int IW       = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
    localparam int IXW      = IW + 1;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_DIV1   = 4'd2;
    localparam logic [3:0] ST_DIV2   = 4'd3;
    localparam logic [3:0] ST_LOOKUP = 4'd4;
    localparam logic [3:0] ST_HIT    = 4'd5;
    localparam logic [3:0] ST_SCAN   = 4'd6;
    localparam logic [3:0] ST_PTWR   = 4'd7;
    localparam logic [3:0] ST_DONE   = 4'd8;

    typedef struct packed {
        logic          valid;
        logic [FW-1:0] frame;
    } pt_entry_t;

    typedef struct packed {
        logic [SW-1:0]  slot;
        logic [PGW-1:0] page;
        logic           referenced;
        logic           dirty;
    } ft_entry_t;

    function automatic logic [IW-1:0] pt_index(logic [SW-1:0] s, logic [PGW-1:0] p);
        return IW'(IXW'(s) * IXW'(PAGES_PER_PROCESS) + IXW'(p));
    endfunction

    // Memories
    pt_entry_t pt_mem [PT_DEPTH];
    ft_entry_t ft_mem [FRAMES];
    pt_entry_t pt_rdata_reg;
    ft_entry_t ft_rdata_reg;

    logic            pt_we;
    logic [IW-1:0]   pt_waddr;
    pt_entry_t       pt_wdata;
    logic            pt_re;
    logic [IW-1:0]   pt_raddr;
    logic            ft_we;
    logic [FW-1:0]   ft_waddr;
    ft_entry_t       ft_wdata;
    logic            ft_re;
    logic [FW-1:0]   ft_raddr;

    // Control and work registers
    logic [3:0]     state_reg, state_next;
    logic [IW-1:0]  clr_reg, clr_next;
    logic [FW-1:0]  head_reg, head_next;
    logic [UW-1:0]  used_reg, used_next;
    logic [UW-1:0]  chances_reg, chances_next;
    logic [FW-1:0]  frame_reg, frame_next;
    logic           fault_reg, fault_next;
    logic           evict_reg, evict_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic [PGW-1:0] page_reg, page_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic           wr_reg;

    logic                             out_valid_reg;
    logic [pfsc_pkg::FRAME_NUM_W-1:0] frame_number_reg;
    logic                             page_fault_reg;
    logic                             evicted_reg;
    logic [pfsc_pkg::CHANCE_W-1:0]    second_chances_reg;

    logic                          in_accept;
    logic                          out_free;
    logic                          page_start;
    logic [FW-1:0]                 head_inc;
    logic                          slot_done;
    logic [pfsc_pkg::SLOT_W-1:0]   slot_rem;
    logic                          addr_done;
    logic [pfsc_pkg::ADDR_W-1:0]   addr_quot;
    logic                          page_done;
    logic [pfsc_pkg::ADDR_W-1:0]   page_rem;

    assign in_accept = in_valid && (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign head_inc  = (head_reg == FW'(FRAMES - 1)) ? '0 : head_reg + 1'b1;

    // Slot and page reduction
    pfsc_cdiv #(
        .WIDTH   (pfsc_pkg::SLOT_W),
        .DIVISOR (PROCESSES)
    ) u_slot_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .dividend  (process_slot),
        .done      (slot_done),
        .quotient  (),
        .remainder (slot_rem)
    );

    pfsc_cdiv #(
        .WIDTH   (pfsc_pkg::ADDR_W),
        .DIVISOR (PAGE_BYTES)
    ) u_addr_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .dividend  (byte_address),
        .done      (addr_done),
        .quotient  (addr_quot),
        .remainder ()
    );

    pfsc_cdiv #(
        .WIDTH   (pfsc_pkg::ADDR_W),
        .DIVISOR (PAGES_PER_PROCESS)
    ) u_page_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (page_start),
        .dividend  (addr_quot),
        .done      (page_done),
        .quotient  (),
        .remainder (page_rem)
    );

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        head_next    = head_reg;
        used_next    = used_reg;
        chances_next = chances_reg;
        frame_next   = frame_reg;
        fault_next   = fault_reg;
        evict_next   = evict_reg;
        slot_next    = slot_reg;
        page_next    = page_reg;
        idx_next     = idx_reg;
        page_start   = 1'b0;
        pt_we        = 1'b0;
        pt_waddr     = idx_reg;
        pt_wdata     = '{valid: 1'b1, frame: frame_reg};
        pt_re        = 1'b0;
        pt_raddr     = idx_reg;
        ft_we        = 1'b0;
        ft_waddr     = frame_reg;
        ft_wdata     = '{slot: slot_reg, page: page_reg, referenced: 1'b1, dirty: wr_reg};
        ft_re        = 1'b0;
        ft_raddr     = head_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the page table invalid
                pt_we    = 1'b1;
                pt_waddr = clr_reg;
                pt_wdata = '0;
                if (clr_reg == IW'(PT_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1:
            begin
                if (addr_done && slot_done)
                begin
                    slot_next  = SW'(slot_rem);
                    page_start = 1'b1;
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2:
            begin
                // Look up the page entry
                if (page_done)
                begin
                    page_next  = PGW'(page_rem);
                    idx_next   = pt_index(slot_reg, PGW'(page_rem));
                    pt_re      = 1'b1;
                    pt_raddr   = idx_next;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                chances_next = '0;
                evict_next   = 1'b0;
                if (pt_rdata_reg.valid)
                begin
                    fault_next = 1'b0;
                    frame_next = pt_rdata_reg.frame;
                    ft_re      = 1'b1;
                    ft_raddr   = pt_rdata_reg.frame;
                    state_next = ST_HIT;
                end
                else if (used_reg < UW'(FRAMES))
                begin
                    // Hand out the lowest unused frame
                    fault_next = 1'b1;
                    frame_next = FW'(used_reg);
                    used_next  = used_reg + 1'b1;
                    ft_we      = 1'b1;
                    ft_waddr   = FW'(used_reg);
                    state_next = ST_PTWR;
                end
                else
                begin
                    fault_next = 1'b1;
                    ft_re      = 1'b1;
                    ft_raddr   = head_reg;
                    state_next = ST_SCAN;
                end
            end
            ST_HIT:
            begin
                // Mark the frame referenced, dirty on write
                ft_we      = 1'b1;
                ft_waddr   = frame_reg;
                ft_wdata   = '{slot: ft_rdata_reg.slot, page: ft_rdata_reg.page,
                               referenced: 1'b1, dirty: ft_rdata_reg.dirty | wr_reg};
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                ft_we     = 1'b1;
                ft_waddr  = head_reg;
                head_next = head_inc;
                if (ft_rdata_reg.referenced || ft_rdata_reg.dirty)
                begin
                    // Second chance: clear marks, move on to the next frame
                    ft_wdata     = '{slot: ft_rdata_reg.slot, page: ft_rdata_reg.page,
                                     referenced: 1'b0, dirty: 1'b0};
                    chances_next = chances_reg + 1'b1;
                    ft_re        = 1'b1;
                    ft_raddr     = head_inc;
                end
                else
                begin
                    // Evict: drop the old owner's mapping, take the frame
                    pt_we      = 1'b1;
                    pt_waddr   = pt_index(ft_rdata_reg.slot, ft_rdata_reg.page);
                    pt_wdata   = '0;
                    frame_next = head_reg;
                    evict_next = 1'b1;
                    state_next = ST_PTWR;
                end
            end
            ST_PTWR:
            begin
                pt_we      = 1'b1;
                pt_waddr   = idx_reg;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            head_reg  <= '0;
            used_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            used_reg  <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chances_reg <= chances_next;
        frame_reg   <= frame_next;
        fault_reg   <= fault_next;
        evict_reg   <= evict_next;
        slot_reg    <= slot_next;
        page_reg    <= page_next;
        idx_reg     <= idx_next;
        if (in_accept)
        begin
            wr_reg <= is_write;
        end
    end

    // Page table memory
    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        if (pt_re)
        begin
            pt_rdata_reg <= pt_mem[pt_raddr];
        end
    end

    // Frame table memory
    always_ff @(posedge clk)
    begin
        if (ft_we)
        begin
            ft_mem[ft_waddr] <= ft_wdata;
        end
        if (ft_re)
        begin
            ft_rdata_reg <= ft_mem[ft_raddr];
        end
    end

    // Output register: hold the word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DONE) && out_free)
        begin
            frame_number_reg   <= pfsc_pkg::FRAME_NUM_W'(frame_reg);
            page_fault_reg     <= fault_reg;
            evicted_reg        <= evict_reg;
            second_chances_reg <= pfsc_pkg::CHANCE_W'(chances_reg);
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign frame_number   = frame_number_reg;
    assign page_fault     = page_fault_reg;
    assign evicted        = evicted_reg;
    assign second_chances = second_chances_reg;

endmodule

FILE: hw/rtl/pfsc_checker.sv
module pfsc_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic [pfsc_pkg::SLOT_W-1:0]      process_slot,
    input logic [pfsc_pkg::ADDR_W-1:0]      byte_address,
    input logic                             is_write,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [pfsc_pkg::FRAME_NUM_W-1:0] frame_number,
    input logic                             page_fault,
    input logic                             evicted,
    input logic [pfsc_pkg::CHANCE_W-1:0]    second_chances
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pend_reg;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Track words accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pend_reg <= pend_reg + 1'b1;
        end
        else if (out_acc && !in_acc)
        begin
            pend_reg <= pend_reg - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_number)
            && $stable(page_fault) && $stable(evicted) && $stable(second_chances))
        else $error("result word changed while stalled");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result word without an accepted access");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> pend_reg <= 2'd1)
        else $error("access accepted while another is still at work");

    a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !page_fault |-> !evicted && second_chances == '0)
        else $error("hit reports eviction or second chances");

    a_chance_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && second_chances != '0 |-> evicted && page_fault)
        else $error("second chances given without an eviction");

endmodule

bind page_fault_second_chance_manager pfsc_checker u_pfsc_checker (.*);

FILE: tb/sv/page_fault_second_chance_manager_test.sv
module page_fault_second_chance_manager_test;

    localparam int PAGE_SLOTS  = pfsc_pkg::DEF_PROCESSES * pfsc_pkg::DEF_PAGES_PER_PROCESS;
    localparam int PAGE_IDX_W  = $clog2(PAGE_SLOTS);
    localparam int PAGE_NUM_W  = $clog2(pfsc_pkg::DEF_PAGES_PER_PROCESS);
    localparam int OFFSET_W    = $clog2(pfsc_pkg::DEF_PAGE_BYTES);
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [pfsc_pkg::SLOT_W-1:0] slot;
        logic [pfsc_pkg::ADDR_W-1:0] addr;
        logic                        wr;
    } access_word_t;

    typedef struct packed {
        logic [pfsc_pkg::FRAME_NUM_W-1:0] frame;
        logic                             fault;
        logic                             evict;
        logic [pfsc_pkg::CHANCE_W-1:0]    chances;
    } access_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic [pfsc_pkg::SLOT_W-1:0]      process_slot = '0;
    logic [pfsc_pkg::ADDR_W-1:0]      byte_address = '0;
    logic                             is_write = 1'b0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [pfsc_pkg::FRAME_NUM_W-1:0] frame_number;
    logic                             page_fault;
    logic                             evicted;
    logic [pfsc_pkg::CHANCE_W-1:0]    second_chances;

    // Shadow of the page table, frame table and replacement ring
    bit                             pt_valid [PAGE_SLOTS];
    bit [pfsc_pkg::FRAME_NUM_W-1:0] pt_frame [PAGE_SLOTS];
    bit [pfsc_pkg::SLOT_W-1:0]      fr_slot [pfsc_pkg::DEF_FRAMES];
    bit [PAGE_NUM_W-1:0]            fr_page [pfsc_pkg::DEF_FRAMES];
    bit                             fr_ref [pfsc_pkg::DEF_FRAMES];
    bit                             fr_dirty [pfsc_pkg::DEF_FRAMES];
    bit [pfsc_pkg::FRAME_NUM_W-1:0] ring [pfsc_pkg::DEF_FRAMES];
    bit [pfsc_pkg::FRAME_NUM_W-1:0] ring_head = '0;
    bit [pfsc_pkg::FRAME_NUM_W-1:0] ring_tail = '0;
    int                             frames_used = 0;

    access_word_t   pending_words[$];
    access_result_t expected_results[$];
    int             recent_pages[$];

    int issued_count = 0;
    int accepted_count = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    access_word_t   next_word;
    access_result_t seen;
    access_result_t want;

    page_fault_second_chance_manager dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .process_slot   (process_slot),
        .byte_address   (byte_address),
        .is_write       (is_write),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_number   (frame_number),
        .page_fault     (page_fault),
        .evicted        (evicted),
        .second_chances (second_chances)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Resolve one access against the shadow tables and advance them
    function automatic access_result_t resolve_access(
        input logic [pfsc_pkg::SLOT_W-1:0] slot,
        input logic [pfsc_pkg::ADDR_W-1:0] addr,
        input logic wr);
        access_result_t                   r;
        logic [PAGE_IDX_W-1:0]            idx;
        logic [pfsc_pkg::FRAME_NUM_W-1:0] f;
        r = '0;
        f = '0;
        idx = {slot, addr[pfsc_pkg::ADDR_W-1 -: PAGE_NUM_W]};
        if (pt_valid[idx])
        begin
            // hit: mark the frame
            f = pt_frame[idx];
            fr_ref[f] = 1'b1;
            if (wr)
                fr_dirty[f] = 1'b1;
        end
        else
        begin
            r.fault = 1'b1;
            if (frames_used < pfsc_pkg::DEF_FRAMES)
            begin
                f = frames_used[pfsc_pkg::FRAME_NUM_W-1:0];
                frames_used++;
            end
            else
            begin
                // scan the ring: clear marked frames and send them to the back
                r.evict = 1'b1;
                for (int i = 0; i <= pfsc_pkg::DEF_FRAMES; i++)
                begin
                    f = ring[ring_head];
                    ring_head = ring_head + 1'b1;
                    if (!fr_ref[f] && !fr_dirty[f])
                        break;
                    fr_ref[f] = 1'b0;
                    fr_dirty[f] = 1'b0;
                    ring[ring_tail] = f;
                    ring_tail = ring_tail + 1'b1;
                    r.chances = r.chances + 1'b1;
                end
                pt_valid[{fr_slot[f], fr_page[f]}] = 1'b0;
            end
            pt_valid[idx] = 1'b1;
            pt_frame[idx] = f;
            fr_slot[f] = slot;
            fr_page[f] = idx[PAGE_NUM_W-1:0];
            fr_ref[f] = 1'b1;
            fr_dirty[f] = wr;
            ring[ring_tail] = f;
            ring_tail = ring_tail + 1'b1;
        end
        r.frame = f;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic queue_word(input int slot, input int addr, input bit wr);
        access_word_t w;
        w.slot = slot[pfsc_pkg::SLOT_W-1:0];
        w.addr = addr[pfsc_pkg::ADDR_W-1:0];
        w.wr = wr;
        pending_words.push_back(w);
        issued_count++;
    endtask

    // Mix of recent pages (mostly hits), the lowest 64 pages and the whole page space
    task automatic queue_random_words(input int count);
        int page_key;
        for (int i = 0; i < count; i++)
        begin
            if (recent_pages.size() > 0 && $urandom_range(99) < 40)
                page_key = recent_pages[$urandom_range(recent_pages.size() - 1)];
            else if ($urandom_range(99) < 30)
                page_key = $urandom_range(63);
            else
                page_key = $urandom_range(PAGE_SLOTS - 1);
            recent_pages.push_back(page_key);
            if (recent_pages.size() > 24)
                void'(recent_pages.pop_front());
            queue_word(page_key >> PAGE_NUM_W,
                       ((page_key % pfsc_pkg::DEF_PAGES_PER_PROCESS) << OFFSET_W)
                           | $urandom_range(pfsc_pkg::DEF_PAGE_BYTES - 1),
                       1'($urandom_range(1)));
        end
    endtask

    task automatic wait_quiet();
        while (accepted_count != issued_count || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Drive input words; hold a stalled word, otherwise offer the next or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(resolve_access(process_slot, byte_address,
                                                          is_write));
                accepted_count++;
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    process_slot <= next_word.slot;
                    byte_address <= next_word.addr;
                    is_write <= next_word.wr;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Count down a long hold-off of the result side
    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Stall the result side at random, or solidly during a hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen.frame = frame_number;
            seen.fault = page_fault;
            seen.evict = evicted;
            seen.chances = second_chances;
            if (expected_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word frame=%0d fault=%0b",
                                          seen.frame, seen.fault));
            end
            else
            begin
                want = expected_results.pop_front();
                if (seen.frame !== want.frame)
                    report_mismatch($sformatf("frame_number got %0d expected %0d",
                                              seen.frame, want.frame));
                if (seen.fault !== want.fault)
                    report_mismatch($sformatf("page_fault got %0b expected %0b",
                                              seen.fault, want.fault));
                if (seen.evict !== want.evict)
                    report_mismatch($sformatf("evicted got %0b expected %0b",
                                              seen.evict, want.evict));
                if (seen.chances !== want.chances)
                    report_mismatch($sformatf("second_chances got %0d expected %0d",
                                              seen.chances, want.chances));
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("page_fault_second_chance_manager_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        int miss_key;

        // fills, hits on read and write, page edges and extreme slots
        queue_word(0, 0, 1'b0);
        queue_word(0, 0, 1'b1);
        queue_word(0, 1023, 1'b0);
        queue_word(0, 1024, 1'b1);
        queue_word(0, 2047, 1'b0);
        queue_word(15, 32767, 1'b1);
        queue_word(15, 31744, 1'b0);
        queue_word(15, 0, 1'b0);
        queue_word(0, 32767, 1'b0);
        queue_word(15, 32767, 1'b0);
        queue_word(5, 15'h5555, 1'b1);
        queue_word(10, 15'h2AAA, 1'b0);
        queue_word(10, 15'h2AAA, 1'b1);
        queue_word(5, 15'h5400, 1'b0);
        queue_word(7, 16384, 1'b1);
        queue_word(8, 16383, 1'b0);
        queue_word(0, 0, 1'b0);
        queue_word(15, 1023, 1'b1);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        wait_quiet();

        // no idling
        queue_random_words(400);
        wait_quiet();

        // sender mostly idle
        sender_idle_pct = 79;
        queue_random_words(300);
        wait_quiet();

        // receiver mostly stalling
        sender_idle_pct = 0;
        recv_stall_pct = 79;
        queue_random_words(300);
        wait_quiet();

        // both idling a quarter of the time
        sender_idle_pct = 25;
        recv_stall_pct = 25;
        queue_random_words(250);
        wait_quiet();

        // touch every resident page, then miss: every frame gets a second chance
        for (int p = 0; p < PAGE_SLOTS; p++)
        begin
            if (pt_valid[p])
                queue_word(p >> PAGE_NUM_W,
                           ((p % pfsc_pkg::DEF_PAGES_PER_PROCESS) << OFFSET_W)
                               | $urandom_range(pfsc_pkg::DEF_PAGE_BYTES - 1),
                           1'($urandom_range(1)));
        end
        miss_key = 0;
        while (pt_valid[miss_key])
            miss_key++;
        queue_word(miss_key >> PAGE_NUM_W,
                   (miss_key % pfsc_pkg::DEF_PAGES_PER_PROCESS) << OFFSET_W, 1'b0);
        wait_quiet();

        // hold off the result side while words keep coming
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 400;
        queue_random_words(60);
        wait_quiet();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("page_fault_second_chance_manager_test: done, clean");
        else
            $display("page_fault_second_chance_manager_test: done, errors");
        $finish;
    end

endmodule
